// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants for the string period detector.
package spd_pkg;

  localparam int MaxLen  = 32;
  localparam int IdxW    = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CntW    = $clog2(MaxLen + 1);
  localparam int SymW    = 8;
  localparam int PeriodW = 6;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
  } spd_in_t;

  typedef struct packed {
    logic               repetitive;
    logic [PeriodW-1:0] period;
    logic               overflow;
  } spd_out_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } spd_div_req_t;

  typedef struct packed {
    logic done;
    logic exact;
  } spd_div_rsp_t;

endpackage

// ===== hw/rtl/spd_rem.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
module spd_rem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spd_pkg::spd_div_req_t req_i,
  output spd_pkg::spd_div_rsp_t rsp_o
);
  import spd_pkg::*;

  localparam int StepW = $clog2(CntW + 1);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  num_q;
  logic [CntW-1:0]  den_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW:0]    rem_w;
  logic [CntW:0]    diff_w;
  logic             ge_w;

  assign rem_w  = {rem_q, num_q[CntW-1]};
  assign diff_w = rem_w - {1'b0, den_q};
  assign ge_w   = rem_w >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (step_q == StepW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= StepW'(CntW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[CntW-2:0], 1'b0};
      rem_q <= ge_w ? diff_w[CntW-1:0] : rem_w[CntW-1:0];
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.exact = (rem_q == '0);

endmodule

// ===== hw/rtl/string_period_detector_unit.sv =====
// String period detector: online KMP prefix table, smallest period on the last byte.
//
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one byte per item,
// with last set on the final byte of a string. Output channel (out_valid_o /
// out_ready_i / out_item_o) gives one item per string: period, repetitive and
// overflow flags.
// The first byte of a string is stored straight from the idle state; each later
// byte is accepted and then compared in a memory lookup, with one more lookup
// for each fallback step through the prefix table; fallbacks total at most the
// string length per string. The symbol and prefix memories are single synchronous
// arrays, each read once per cycle.
// After the last byte the remainder unit checks that the period divides the length;
// its result passes through the result register to the output register. Strings
// longer than the maximum only count as overflow.
// The output register holds its item until taken; a new string may start
// while it waits, but the next result stalls until the register frees up.
// Reset clears the string length, match length and flags; the memories are
// not cleared, as only entries written earlier in the same string are read.
module string_period_detector_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spd_pkg::spd_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spd_pkg::spd_out_t out_item_o
);
  import spd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } spd_state_e;

  spd_state_e state_q, state_d;
  logic [IdxW-1:0] match_q, match_d;
  logic [CntW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [CntW-1:0] per_q, per_d;
  logic            half_q, half_d;
  logic [SymW-1:0] sym_b_q;
  logic            last_q;
  spd_out_t        res_q, res_d;
  spd_out_t        out_q;
  logic            out_valid_q;

  logic [SymW-1:0] sym_mem [MaxLen];
  logic [IdxW-1:0] pfx_mem [MaxLen];
  logic [SymW-1:0] sym_rd_q;
  logic [IdxW-1:0] pfx_rd_q;

  logic            cap;
  logic            load_out;
  logic            sym_we;
  logic            pfx_we;
  logic [IdxW-1:0] pfx_wd;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] pos;
  logic            full;
  logic            hit;
  logic [IdxW-1:0] jn;
  logic [CntW-1:0] len_inc;
  logic [CntW-1:0] per_calc;
  logic            half_calc;

  spd_div_req_t div_req;
  spd_div_rsp_t div_rsp;

  spd_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pos       = len_q[IdxW-1:0];
  assign full      = (len_q == CntW'(MaxLen));
  assign hit       = (sym_rd_q == sym_b_q);
  assign jn        = hit ? IdxW'(j_q + 1'b1) : '0;
  assign len_inc   = len_q + 1'b1;
  assign per_calc  = len_inc - CntW'(jn);
  assign half_calc = ({per_calc, 1'b0} <= {1'b0, len_inc});

  always_comb begin
    state_d  = state_q;
    match_d  = match_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    j_d      = j_q;
    per_d    = per_q;
    half_d   = half_q;
    res_d    = res_q;
    rd_addr  = match_q;
    sym_we   = 1'b0;
    pfx_we   = 1'b0;
    pfx_wd   = '0;
    cap      = 1'b0;
    load_out = 1'b0;
    div_req  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (full) begin
            ovf_d = 1'b1;
            if (in_item_i.last) begin
              res_d = '{repetitive: 1'b0, period: '0, overflow: 1'b1};
              ovf_d   = 1'b0;
              len_d   = '0;
              match_d = '0;
              state_d = ST_DONE;
            end
          end else begin
            sym_we = 1'b1;
            if (len_q == '0) begin
              pfx_we  = 1'b1;
              match_d = '0;
              len_d   = CntW'(1);
              if (in_item_i.last) begin
                res_d = '{repetitive: 1'b0, period: PeriodW'(1), overflow: 1'b0};
                len_d   = '0;
                state_d = ST_DONE;
              end
            end else begin
              cap     = 1'b1;
              j_d     = match_q;
              state_d = ST_LOOK;
            end
          end
        end
      end
      ST_LOOK: begin
        if (j_q != '0 && !hit) begin
          j_d     = pfx_rd_q;
          rd_addr = pfx_rd_q;
        end else begin
          pfx_we  = 1'b1;
          pfx_wd  = jn;
          match_d = jn;
          len_d   = len_inc;
          state_d = ST_IDLE;
          if (last_q) begin
            div_req.start    = 1'b1;
            div_req.dividend = len_inc;
            div_req.divisor  = per_calc;
            per_d   = per_calc;
            half_d  = half_calc;
            match_d = '0;
            len_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_d = '{repetitive: div_rsp.exact & half_q,
                    period: PeriodW'(per_q), overflow: 1'b0};
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      match_q     <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      match_q <= match_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    per_q  <= per_d;
    half_q <= half_d;
    res_q  <= res_d;
    if (cap) begin
      sym_b_q <= in_item_i.symbol;
      last_q  <= in_item_i.last;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[pos] <= in_item_i.symbol;
    end
    sym_rd_q <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pfx_we) begin
      pfx_mem[pos] <= pfx_wd;
    end
    pfx_rd_q <= pfx_mem[IdxW'(rd_addr - 1'b1)];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/spd_checker.sv =====
// Port-level checker for the string period detector, bound to the top level.
module spd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input spd_pkg::spd_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input spd_pkg::spd_out_t out_item_o
);
  import spd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  a_ovf_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |->
      !out_item_o.repetitive && out_item_o.period == '0)
    else $error("overflow item carries period or repetitive flag");

  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.overflow |-> out_item_o.period != '0)
    else $error("zero period on a normal item");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.last |=> !in_ready_o)
    else $error("input ready right after the last byte");

endmodule

bind string_period_detector_unit spd_checker u_spd_checker (.*);

// ===== bench/tb_string_period_detector_unit.sv =====
// Self-checking testbench for the string period detector unit.
`timescale 1ns / 1ps

module tb_string_period_detector_unit;
  import spd_pkg::*;

  typedef logic [SymW-1:0] sym_q_t[$];

  class period_scoreboard;
    logic [SymW-1:0] sym_store[MaxLen];
    int              border_tab[MaxLen];
    int              border_len;
    int              str_len;
    bit              too_long;
    spd_out_t        expected_q[$];
    int              errors;

    function void note_byte(spd_in_t it);
      spd_out_t res;
      int       j;
      int       p;
      if (str_len >= MaxLen) begin
        too_long = 1'b1;
      end else begin
        sym_store[str_len] = it.symbol;
        j = border_len;
        if (str_len == 0) begin
          j = 0;
        end else begin
          while (j > 0 && j < str_len && sym_store[j] != it.symbol) j = border_tab[j-1];
          if (j < str_len && sym_store[j] == it.symbol) j++;
        end
        border_tab[str_len] = j;
        border_len = j;
        str_len++;
      end
      if (!it.last) return;
      res = '0;
      if (too_long) begin
        res.overflow = 1'b1;
      end else begin
        p = str_len;
        if (str_len >= 2) begin
          p = str_len - border_tab[str_len-1];
          res.repetitive = (p >= 1) && (str_len % p == 0) && (str_len / p >= 2);
        end
        res.period = p[PeriodW-1:0];
      end
      expected_q.push_back(res);
      border_len = 0;
      str_len = 0;
      too_long = 1'b0;
    endfunction

    function void check_result(spd_out_t got);
      spd_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.repetitive !== want.repetitive) begin
        $display("%0t: repetitive expected %b actual %b", $time, want.repetitive,
                 got.repetitive);
        errors++;
      end
      if (got.period !== want.period) begin
        $display("%0t: period expected %0d actual %0d", $time, want.period, got.period);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int NumItems   = 1250;
  localparam int CalmItems  = 1100;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  spd_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spd_out_t out_item;

  period_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  string_period_detector_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_byte(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HoldCycles;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  task automatic push_byte(input logic [SymW-1:0] s, input logic l);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{symbol: s, last: l};
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    sent++;
    if (sent >= CalmItems) idle_on = 1'b0;
  endtask

  task automatic send_string(input sym_q_t q);
    foreach (q[i]) push_byte(q[i], i == q.size() - 1);
  endtask

  function automatic sym_q_t make_string();
    sym_q_t          q;
    logic [SymW-1:0] pat[8];
    logic [SymW-1:0] base;
    int              mode;
    int              plen;
    int              n;
    mode = $urandom_range(0, 99);
    base = 8'($urandom);
    if (mode < 60) begin
      plen = $urandom_range(1, 8);
      foreach (pat[i]) begin
        pat[i] = 8'(($urandom_range(0, 3) == 0) ? $urandom
                                                : base + $urandom_range(0, 1));
      end
      n = plen * $urandom_range(2, MaxLen / plen);
      if (mode >= 45) n = n - $urandom_range(0, plen - 1);
      for (int i = 0; i < n; i++) q.push_back(pat[i % plen]);
      if (mode >= 52) q[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (mode < 80) begin
      n = $urandom_range(1, MaxLen);
      for (int i = 0; i < n; i++) q.push_back(base ^ 8'($urandom_range(0, 1)));
    end else if (mode < 94) begin
      n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(1, MaxLen);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(MaxLen + 1, MaxLen + 8);
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  spd_in_t directed[20] = '{
    '{8'h00, 1'b1},
    '{8'hff, 1'b0}, '{8'hff, 1'b1},
    '{8'ha5, 1'b0}, '{8'h5a, 1'b0}, '{8'ha5, 1'b0}, '{8'h5a, 1'b1},
    '{8'h01, 1'b0}, '{8'h02, 1'b0}, '{8'h01, 1'b1},
    '{8'h80, 1'b0}, '{8'h7f, 1'b0}, '{8'h80, 1'b0}, '{8'h7f, 1'b0}, '{8'h80, 1'b1},
    '{8'haa, 1'b0}, '{8'haa, 1'b0}, '{8'hab, 1'b1},
    '{8'h0f, 1'b0}, '{8'hf0, 1'b1}
  };

  initial begin
    sym_q_t q;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) push_byte(directed[i].symbol, directed[i].last);

    // full-length repetition, then an overflow, while the output is held off
    hold_req = 1'b1;
    q = {};
    for (int i = 0; i < MaxLen; i++) q.push_back(8'h3c + 8'(i % 4));
    send_string(q);
    q = {};
    for (int i = 0; i < MaxLen + 4; i++) q.push_back(8'($urandom));
    send_string(q);

    while (sent < NumItems) send_string(make_string());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spd_pkg.sv
hw/rtl/spd_rem.sv
hw/rtl/string_period_detector_unit.sv
hw/rtl/spd_checker.sv
bench/tb_string_period_detector_unit.sv
